### design/dsfr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_pkg
// Shared codes, widths and result type of the DLE/STX/ETX frame receiver.
// ---------------------------------------------------------------------------
package dsfr_pkg;

   localparam logic [7:0] DLE_CODE = 8'h10;
   localparam logic [7:0] STX_CODE = 8'h02;
   localparam logic [7:0] ETX_CODE = 8'h03;

   localparam int BUFFER_BYTES_DEFAULT = 512;
   localparam int HEADER_BYTES_DEFAULT = 6;
   localparam int TAG_BYTES_DEFAULT    = 16;

   // width of the reported frame length
   localparam int FRAME_LEN_W = 10;
   // length arithmetic wide enough for any legal parameter set
   localparam int CALC_W = 12;

   typedef enum logic [1:0] {
      VERDICT_VALID     = 2'd0,
      VERDICT_SHORT     = 2'd1,
      VERDICT_BAD_LEN   = 2'd2,
      VERDICT_OVERFLOW  = 2'd3
   } verdict_type;

   typedef struct packed {
      logic                   is_frame_end;
      logic [7:0]             data_byte;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic [7:0]             frame_seq;
      logic [7:0]             cipher_length;
      verdict_type            verdict;
   } result_type;

endpackage

### design/dle_stx_etx_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dle_stx_etx_frame_receiver_unit
// Removes DLE byte stuffing from a serial byte stream and reports frames.
//
// The req channel carries one raw serial byte per transaction. DLE STX opens
// a frame; inside it DLE DLE gives a 0x10 data byte, DLE ETX closes it, and
// DLE followed by any other byte drops both. Outside a frame bytes produce
// nothing. Each data byte gives one rsp transaction, and closing a frame
// gives one end-of-frame transaction with length, sequence byte, cipher
// length and verdict.
// Throughput is one byte per cycle while req_ready is high: the mode machine updates on each byte taken.
// A result is registered in an output entry before it shows on rsp. Two result
// entries sit on the rsp side, so when the receiver stalls req_ready stays
// high until both are full and rises again the cycle after one is taken.
// Reset (synchronous) returns to idle with no frame open and empties both
// result entries.
// ---------------------------------------------------------------------------
module dle_stx_etx_frame_receiver_unit #(
   parameter int BUFFER_BYTES = dsfr_pkg::BUFFER_BYTES_DEFAULT,
   parameter int HEADER_BYTES = dsfr_pkg::HEADER_BYTES_DEFAULT,
   parameter int TAG_BYTES    = dsfr_pkg::TAG_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_is_frame_end,
   output logic [7:0]                       rsp_data_byte,
   output logic [dsfr_pkg::FRAME_LEN_W-1:0] rsp_frame_length,
   output logic [7:0]                       rsp_frame_seq,
   output logic [7:0]                       rsp_cipher_length,
   output logic [1:0]                       rsp_verdict
);
   import dsfr_pkg::*;

   logic       accept;
   logic       res_valid;
   result_type res;
   result_type out_data;

   assign accept = req_valid && req_ready;

   dsfr_framer #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .TAG_BYTES    (TAG_BYTES)
   ) u_framer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   dsfr_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_is_frame_end  = out_data.is_frame_end;
   assign rsp_data_byte     = out_data.data_byte;
   assign rsp_frame_length  = out_data.frame_length;
   assign rsp_frame_seq     = out_data.frame_seq;
   assign rsp_cipher_length = out_data.cipher_length;
   assign rsp_verdict       = out_data.verdict;

endmodule

### design/dsfr_framer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_framer
// Unstuffing state machine: tracks frame mode, counts kept bytes, captures
// the header fields and builds the data or end-of-frame result.
// ---------------------------------------------------------------------------
module dsfr_framer #(
   parameter int BUFFER_BYTES = dsfr_pkg::BUFFER_BYTES_DEFAULT,
   parameter int HEADER_BYTES = dsfr_pkg::HEADER_BYTES_DEFAULT,
   parameter int TAG_BYTES    = dsfr_pkg::TAG_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   output logic                 res_valid,
   output dsfr_pkg::result_type res
);
   import dsfr_pkg::*;

   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_IDLE_DLE  = 2'd1,
      MODE_FRAME     = 2'd2,
      MODE_FRAME_DLE = 2'd3
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       len_ff, len_in;
   logic             ovf_ff, ovf_in;

   logic              keep;
   logic              end_frame;
   logic              opening;
   logic [7:0]        keep_data;
   logic [7:0]        clen;
   logic [CALC_W-1:0] count_ext;
   logic [CALC_W-1:0] need_len;

   assign clen      = len_ff - 8'(TAG_BYTES);
   assign count_ext = CALC_W'(count_ff);
   assign need_len  = CALC_W'(HEADER_BYTES) + CALC_W'(clen) + CALC_W'(TAG_BYTES);

   always_comb begin
      mode_in   = mode_ff;
      keep      = 1'b0;
      end_frame = 1'b0;
      opening   = 1'b0;
      keep_data = rx_byte;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (rx_byte == DLE_CODE) mode_in = MODE_IDLE_DLE;
         end
         MODE_IDLE_DLE: begin
            if (rx_byte == STX_CODE) begin
               opening = 1'b1;
               mode_in = MODE_FRAME;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_FRAME: begin
            if (rx_byte == DLE_CODE) mode_in = MODE_FRAME_DLE;
            else                     keep    = 1'b1;
         end
         MODE_FRAME_DLE: begin
            if (rx_byte == ETX_CODE) begin
               mode_in   = MODE_IDLE;
               end_frame = 1'b1;
            end else begin
               mode_in = MODE_FRAME;
               // escaped dle is a data byte, anything else drops the pair
               if (rx_byte == DLE_CODE) keep = 1'b1;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      if (opening) begin
         count_in = '0;
         seq_in   = '0;
         len_in   = '0;
         ovf_in   = 1'b0;
      end else if (keep) begin
         if (count_ff < CNT_W'(BUFFER_BYTES)) begin
            if (count_ff == CNT_W'(4)) seq_in = keep_data;
            if (count_ff == CNT_W'(5)) len_in = keep_data;
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_comb begin
      res           = '0;
      res.verdict   = VERDICT_VALID;
      res_valid     = accept && (keep || end_frame);
      if (end_frame) begin
         res.is_frame_end  = 1'b1;
         res.frame_length  = FRAME_LEN_W'(count_ff);
         res.frame_seq     = seq_ff;
         res.cipher_length = clen;
         if (ovf_ff)                                 res.verdict = VERDICT_OVERFLOW;
         else if (count_ext < CALC_W'(HEADER_BYTES)) res.verdict = VERDICT_SHORT;
         else if (clen == 8'd0 || need_len > count_ext) res.verdict = VERDICT_BAD_LEN;
         else                                        res.verdict = VERDICT_VALID;
      end else begin
         res.data_byte = keep_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         seq_ff   <= '0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUFFER_BYTES))
      else $error("byte count beyond buffer size");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == CNT_W'(BUFFER_BYTES))
      else $error("overflow flagged with buffer not full");

   a_etx_closes: assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff == MODE_FRAME_DLE && rx_byte == ETX_CODE |=> mode_ff == MODE_IDLE)
      else $error("frame not closed after dle etx");

endmodule

### design/dsfr_skid.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_skid
// Two-entry output buffer: result register plus skid register, so the
// input side ready does not depend on the result side ready.
// ---------------------------------------------------------------------------
module dsfr_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dsfr_pkg::result_type push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dsfr_pkg::result_type out_data
);
   import dsfr_pkg::*;

   logic       main_valid_ff;
   logic       skid_valid_ff;
   result_type main_ff;
   result_type skid_ff;
   logic       pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff       <= push_data;
            skid_valid_ff <= 1'b1;
         end else begin
            main_ff       <= push_data;
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty result register");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !pop |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry lost without a transaction");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> main_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved to result register");

endmodule
